// ===== src/bench_netlist_statement_parser_assert.svh =====
// Assertion macros for the bench netlist statement parser checks.
// Needs nothing but a clock, an active-low reset and the expressions given.
`ifndef BENCH_NETLIST_STATEMENT_PARSER_ASSERT_SVH
`define BENCH_NETLIST_STATEMENT_PARSER_ASSERT_SVH

// Same-cycle implication, held off during reset
`define BNSP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define BNSP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bnsp_pkg.sv =====
// Shared types, codes and the gate kind table of the bench netlist parser.
// Used by the controller, the datapath, the top level and the checker.
package bnsp_pkg;

    // Field widths
    localparam int NAME_W  = 12;
    localparam int KIND_W  = 5;
    localparam int EVENT_W = 4;
    localparam int GATE_W  = 4;

    // Token kinds
    localparam logic [KIND_W-1:0] TK_LPAR   = 5'd0;
    localparam logic [KIND_W-1:0] TK_RPAR   = 5'd1;
    localparam logic [KIND_W-1:0] TK_EQ     = 5'd2;
    localparam logic [KIND_W-1:0] TK_COMMA  = 5'd3;
    localparam logic [KIND_W-1:0] TK_INPUT  = 5'd4;
    localparam logic [KIND_W-1:0] TK_OUTPUT = 5'd5;
    localparam logic [KIND_W-1:0] TK_BUFF   = 5'd6;
    localparam logic [KIND_W-1:0] TK_NOT    = 5'd7;
    localparam logic [KIND_W-1:0] TK_AND    = 5'd8;
    localparam logic [KIND_W-1:0] TK_NAND   = 5'd9;
    localparam logic [KIND_W-1:0] TK_OR     = 5'd10;
    localparam logic [KIND_W-1:0] TK_NOR    = 5'd11;
    localparam logic [KIND_W-1:0] TK_XOR    = 5'd12;
    localparam logic [KIND_W-1:0] TK_XNOR   = 5'd13;
    localparam logic [KIND_W-1:0] TK_DFF    = 5'd14;
    localparam logic [KIND_W-1:0] TK_NAME   = 5'd15;
    localparam logic [KIND_W-1:0] TK_EOF    = 5'd16;

    // Result events
    localparam logic [EVENT_W-1:0] EV_IN       = 4'd0;
    localparam logic [EVENT_W-1:0] EV_OUT      = 4'd1;
    localparam logic [EVENT_W-1:0] EV_HEAD     = 4'd2;
    localparam logic [EVENT_W-1:0] EV_FANIN    = 4'd3;
    localparam logic [EVENT_W-1:0] EV_SYNTAX   = 4'd4;
    localparam logic [EVENT_W-1:0] EV_REDEF    = 4'd5;
    localparam logic [EVENT_W-1:0] EV_BOTHIO   = 4'd6;
    localparam logic [EVENT_W-1:0] EV_END_OK   = 4'd7;
    localparam logic [EVENT_W-1:0] EV_END_FAIL = 4'd8;

    // Gate kinds
    localparam logic [GATE_W-1:0] GK_BUFF = 4'd0;
    localparam logic [GATE_W-1:0] GK_NOT  = 4'd1;
    localparam logic [GATE_W-1:0] GK_DFF  = 4'd2;
    localparam logic [GATE_W-1:0] GK_AND  = 4'd3;
    localparam logic [GATE_W-1:0] GK_NAND = 4'd4;
    localparam logic [GATE_W-1:0] GK_OR   = 4'd5;
    localparam logic [GATE_W-1:0] GK_NOR  = 4'd6;
    localparam logic [GATE_W-1:0] GK_XOR  = 4'd7;
    localparam logic [GATE_W-1:0] GK_XNOR = 4'd8;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [NAME_W-1:0] name_index;
    } tok_item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [NAME_W-1:0]  signal_index;
        logic [GATE_W-1:0]  gate_kind;
        logic               last;
    } res_item_t;

    // Statement phase
    typedef enum logic [3:0] {
        PH_START, PH_I_LPAR, PH_I_NAME, PH_I_RPAR,
        PH_O_LPAR, PH_O_NAME, PH_O_RPAR,
        PH_G_EQ, PH_G_TYPE, PH_G_LPAR, PH_G_NAME, PH_G_SEP,
        PH_SKIP
    } phase_t;

    // Controller sequencing state
    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_MOD, S_FLAG, S_OUTDECL, S_FANIN, S_EOF_END
    } ctl_state_t;

    // Source of the signal index of a result
    typedef enum logic [1:0] {
        SIG_ZERO, SIG_TARGET, SIG_FANIN
    } sig_sel_t;

    // One word of the name table
    typedef struct packed {
        logic defined;
        logic primary_in;
    } flag_t;

    typedef struct packed {
        logic               tok_load;
        logic               set_target;
        logic               set_gate;
        logic               fan_clear;
        logic               fan_push;
        logic               fan_rd_start;
        logic               fan_rd_step;
        logic               slot_start;
        logic               flag_read;
        logic               flag_write;
        flag_t              flag_wdata;
        logic               clr_run;
        logic               emit;
        logic [EVENT_W-1:0] ev;
        sig_sel_t           sig_sel;
        logic               gate_en;
        logic               last;
    } bnsp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] tok_kind;
        logic              out_free;
        logic              fan_full;
        logic              fan_rd_last;
        logic              slot_busy;
        flag_t             flag;
        logic              clr_last;
    } bnsp_stat_t;

    // Gate kind for the gate type tokens
    function automatic logic [GATE_W-1:0] gate_of_token(input logic [KIND_W-1:0] kind);
        logic [GATE_W-1:0] g;
        case (kind)
            TK_BUFF: g = GK_BUFF;
            TK_NOT:  g = GK_NOT;
            TK_AND:  g = GK_AND;
            TK_NAND: g = GK_NAND;
            TK_OR:   g = GK_OR;
            TK_NOR:  g = GK_NOR;
            TK_XOR:  g = GK_XOR;
            TK_XNOR: g = GK_XNOR;
            TK_DFF:  g = GK_DFF;
            default: g = GK_BUFF;
        endcase
        return g;
    endfunction

endpackage

// ===== src/bnsp_slot_mod.sv =====
// Slot unit: name id modulo the name table depth by reciprocal multiplication.
// Product with the rounded-up reciprocal, then the quotient times the depth off the id.
// Uses bnsp_pkg.
module bnsp_slot_mod #(
    parameter int NAME_COUNT = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bnsp_pkg::NAME_W-1:0]    value,
    output logic                           busy,
    output logic [$clog2(NAME_COUNT)-1:0]  slot
);
    import bnsp_pkg::*;

    localparam int SW = $clog2(NAME_COUNT);
    localparam int SH = NAME_W + SW;
    localparam int MW = NAME_W + 2;
    localparam int PW = NAME_W + MW;
    localparam int DW = NAME_W + SW;
    localparam longint unsigned RECIP =
        ((64'd1 << SH) + longint'(NAME_COUNT) - 64'd1) / longint'(NAME_COUNT);

    logic              busy_reg, busy_next;
    logic [NAME_W-1:0] val_reg, val_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [SW-1:0]     rem_reg, rem_next;
    logic [NAME_W-1:0] quot;
    logic [DW-1:0]     diff;

    // Multiply on start, take the quotient back off the id in the next cycle
    always_comb
    begin
        quot      = NAME_W'(prod_reg >> SH);
        diff      = DW'(val_reg) - DW'(quot) * DW'(NAME_COUNT);
        busy_next = start;
        val_next  = start ? value : val_reg;
        prod_next = start ? PW'(value) * PW'(RECIP) : prod_reg;
        rem_next  = busy_reg ? diff[SW-1:0] : rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    // Hold the id, product and remainder; no reset needed
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
    end

    assign busy = busy_reg;
    assign slot = rem_reg;

endmodule

// ===== src/bnsp_ctrl.sv =====
// Controller: statement phase, error mark and result sequencing.
// Drives the datapath by bnsp_cmd_t and reads bnsp_stat_t; uses bnsp_pkg.
module bnsp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 token_valid,
    output logic                 token_ready,
    input  bnsp_pkg::bnsp_stat_t stat,
    output bnsp_pkg::bnsp_cmd_t  cmd
);
    import bnsp_pkg::*;

    ctl_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic       err_reg, err_next;

    function automatic bnsp_cmd_t with_emit(input bnsp_cmd_t c, input logic [EVENT_W-1:0] ev,
                                            input sig_sel_t s, input logic g, input logic l);
        bnsp_cmd_t r;
        r         = c;
        r.emit    = 1'b1;
        r.ev      = ev;
        r.sig_sel = s;
        r.gate_en = g;
        r.last    = l;
        return r;
    endfunction

    // Next state and commands
    always_comb
    begin
        logic              syn;
        logic              eof;
        logic [KIND_W-1:0] kind;
        syn         = 1'b0;
        eof         = 1'b0;
        kind        = stat.tok_kind;
        cmd         = '0;
        token_ready = 1'b0;
        state_next  = state_reg;
        phase_next  = phase_reg;
        err_next    = err_reg;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_run = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                token_ready = 1'b1;
                if (token_valid)
                begin
                    cmd.tok_load = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (kind == TK_EOF)
                begin
                    if (stat.out_free)
                    begin
                        if (phase_reg == PH_START)
                        begin
                            cmd = with_emit(cmd, err_reg ? EV_END_FAIL : EV_END_OK,
                                            SIG_ZERO, 1'b0, 1'b1);
                            eof = 1'b1;
                        end
                        else if (phase_reg == PH_SKIP)
                        begin
                            cmd = with_emit(cmd, EV_END_FAIL, SIG_ZERO, 1'b0, 1'b1);
                            eof = 1'b1;
                        end
                        else
                        begin
                            cmd = with_emit(cmd, EV_SYNTAX, SIG_ZERO, 1'b0, 1'b0);
                            state_next = S_EOF_END;
                        end
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                    case (phase_reg)
                        PH_START:
                        begin
                            if (kind == TK_INPUT)
                                phase_next = PH_I_LPAR;
                            else if (kind == TK_OUTPUT)
                                phase_next = PH_O_LPAR;
                            else if (kind == TK_NAME)
                            begin
                                cmd.set_target = 1'b1;
                                phase_next     = PH_G_EQ;
                            end
                            else
                                syn = 1'b1;
                        end
                        PH_I_LPAR:
                        begin
                            if (kind == TK_LPAR)
                                phase_next = PH_I_NAME;
                            else
                                syn = 1'b1;
                        end
                        PH_O_LPAR:
                        begin
                            if (kind == TK_LPAR)
                                phase_next = PH_O_NAME;
                            else
                                syn = 1'b1;
                        end
                        PH_I_NAME:
                        begin
                            if (kind == TK_NAME)
                            begin
                                cmd.set_target = 1'b1;
                                phase_next     = PH_I_RPAR;
                            end
                            else
                                syn = 1'b1;
                        end
                        PH_O_NAME:
                        begin
                            if (kind == TK_NAME)
                            begin
                                cmd.set_target = 1'b1;
                                phase_next     = PH_O_RPAR;
                            end
                            else
                                syn = 1'b1;
                        end
                        PH_I_RPAR, PH_O_RPAR:
                        begin
                            if (kind == TK_RPAR)
                            begin
                                cmd.slot_start = 1'b1;
                                state_next     = S_MOD;
                            end
                            else
                                syn = 1'b1;
                        end
                        PH_G_EQ:
                        begin
                            if (kind == TK_EQ)
                                phase_next = PH_G_TYPE;
                            else
                                syn = 1'b1;
                        end
                        PH_G_TYPE:
                        begin
                            if (kind inside {[TK_BUFF:TK_DFF]})
                            begin
                                cmd.set_gate = 1'b1;
                                phase_next   = PH_G_LPAR;
                            end
                            else
                                syn = 1'b1;
                        end
                        PH_G_LPAR:
                        begin
                            if (kind == TK_LPAR)
                            begin
                                cmd.fan_clear = 1'b1;
                                phase_next    = PH_G_NAME;
                            end
                            else
                                syn = 1'b1;
                        end
                        PH_G_NAME:
                        begin
                            if (kind == TK_NAME && !stat.fan_full)
                            begin
                                cmd.fan_push = 1'b1;
                                phase_next   = PH_G_SEP;
                            end
                            else
                                syn = 1'b1;
                        end
                        PH_G_SEP:
                        begin
                            if (kind == TK_COMMA)
                                phase_next = PH_G_NAME;
                            else if (kind == TK_RPAR)
                            begin
                                cmd.slot_start = 1'b1;
                                state_next     = S_MOD;
                            end
                            else
                                syn = 1'b1;
                        end
                        default:
                        begin
                            // skip mode: drop tokens up to the closing paren
                            if (kind == TK_RPAR)
                                phase_next = PH_START;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (!stat.slot_busy)
                begin
                    cmd.flag_read = 1'b1;
                    state_next    = S_FLAG;
                end
            end
            S_FLAG:
            begin
                if (stat.out_free)
                begin
                    phase_next = PH_START;
                    state_next = S_IDLE;
                    case (phase_reg)
                        PH_I_RPAR:
                        begin
                            if (stat.flag.defined)
                            begin
                                cmd      = with_emit(cmd, EV_REDEF, SIG_TARGET, 1'b0, 1'b1);
                                err_next = 1'b1;
                            end
                            else
                            begin
                                cmd = with_emit(cmd, EV_IN, SIG_TARGET, 1'b0, 1'b1);
                                cmd.flag_write = 1'b1;
                                cmd.flag_wdata = '{defined: 1'b1, primary_in: 1'b1};
                            end
                        end
                        PH_O_RPAR:
                        begin
                            if (stat.flag.primary_in)
                            begin
                                cmd = with_emit(cmd, EV_BOTHIO, SIG_TARGET, 1'b0, 1'b0);
                                state_next = S_OUTDECL;
                            end
                            else
                                cmd = with_emit(cmd, EV_OUT, SIG_TARGET, 1'b0, 1'b1);
                        end
                        PH_G_SEP:
                        begin
                            if (stat.flag.defined)
                            begin
                                cmd      = with_emit(cmd, EV_REDEF, SIG_TARGET, 1'b0, 1'b1);
                                err_next = 1'b1;
                            end
                            else
                            begin
                                // gate always has at least one fanin here
                                cmd = with_emit(cmd, EV_HEAD, SIG_TARGET, 1'b1, 1'b0);
                                cmd.flag_write   = 1'b1;
                                cmd.flag_wdata   = '{defined: 1'b1,
                                                     primary_in: stat.flag.primary_in};
                                cmd.fan_rd_start = 1'b1;
                                state_next       = S_FANIN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_OUTDECL:
            begin
                if (stat.out_free)
                begin
                    cmd        = with_emit(cmd, EV_OUT, SIG_TARGET, 1'b0, 1'b1);
                    state_next = S_IDLE;
                end
            end
            S_FANIN:
            begin
                if (stat.out_free)
                begin
                    cmd = with_emit(cmd, EV_FANIN, SIG_FANIN, 1'b1, stat.fan_rd_last);
                    if (stat.fan_rd_last)
                        state_next = S_IDLE;
                    else
                        cmd.fan_rd_step = 1'b1;
                end
            end
            S_EOF_END:
            begin
                if (stat.out_free)
                begin
                    cmd = with_emit(cmd, EV_END_FAIL, SIG_ZERO, 1'b0, 1'b1);
                    eof = 1'b1;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase

        // Report a syntax error, or hold the token until the output frees up
        if (syn)
        begin
            if (stat.out_free)
            begin
                cmd        = with_emit(cmd, EV_SYNTAX, SIG_ZERO, 1'b0, 1'b1);
                err_next   = 1'b1;
                phase_next = (kind == TK_RPAR) ? PH_START : PH_SKIP;
                state_next = S_IDLE;
            end
            else
            begin
                phase_next = phase_reg;
                state_next = S_EXEC;
            end
        end

        // End of file: reset statement state and sweep the name table
        if (eof)
        begin
            err_next      = 1'b0;
            phase_next    = PH_START;
            cmd.fan_clear = 1'b1;
            state_next    = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            phase_reg <= PH_START;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            err_reg   <= err_next;
        end
    end

endmodule

// ===== src/bnsp_dp.sv =====
// Datapath: token, target and gate registers, fanin buffer, name table,
// output register. Uses bnsp_pkg and bnsp_slot_mod.
module bnsp_dp #(
    parameter int NAME_COUNT = 4096,
    parameter int MAX_FANIN  = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bnsp_pkg::tok_item_t  token,
    input  logic                 result_ready,
    output logic                 result_valid,
    output bnsp_pkg::res_item_t  result,
    input  bnsp_pkg::bnsp_cmd_t  cmd,
    output bnsp_pkg::bnsp_stat_t stat
);
    import bnsp_pkg::*;

    localparam int SW = $clog2(NAME_COUNT);
    localparam int IW = $clog2(MAX_FANIN);
    localparam int CW = $clog2(MAX_FANIN + 1);

    tok_item_t         tok_reg;
    logic [NAME_W-1:0] target_reg;
    logic [GATE_W-1:0] gate_reg;
    logic [CW-1:0]     fan_cnt_reg, fan_cnt_next;
    logic [IW-1:0]     fan_rd_idx_reg, fan_rd_idx_next;
    logic [IW-1:0]     fan_rd_addr;
    logic [NAME_W-1:0] fan_rd_reg;
    logic [SW-1:0]     clr_addr_reg, clr_addr_next;
    logic              clr_last;
    flag_t             flag_rd_reg;
    logic              out_valid_reg, out_valid_next;
    res_item_t         out_item_reg, out_item;
    logic              out_free;
    logic [SW-1:0]     slot;
    logic              slot_busy;
    logic              mem_we;
    logic [SW-1:0]     mem_waddr;
    flag_t             mem_wdata;

    logic [NAME_W-1:0] fan_mem [MAX_FANIN];
    flag_t             flag_mem [NAME_COUNT];

    // Table slot of the target name
    bnsp_slot_mod #(
        .NAME_COUNT (NAME_COUNT)
    ) u_slot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.slot_start),
        .value (target_reg),
        .busy  (slot_busy),
        .slot  (slot)
    );

    // Capture the token, target and gate kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            gate_reg   <= '0;
        end
        else
        begin
            if (cmd.set_target)
                target_reg <= tok_reg.name_index;
            if (cmd.set_gate)
                gate_reg <= gate_of_token(tok_reg.token_kind);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tok_load)
            tok_reg <= token;
    end

    // Fanin count and readback index
    always_comb
    begin
        fan_cnt_next = fan_cnt_reg;
        if (cmd.fan_clear)
            fan_cnt_next = '0;
        else if (cmd.fan_push)
            fan_cnt_next = fan_cnt_reg + 1'b1;
        fan_rd_addr     = cmd.fan_rd_start ? '0 : fan_rd_idx_reg + 1'b1;
        fan_rd_idx_next = fan_rd_idx_reg;
        if (cmd.fan_rd_start || cmd.fan_rd_step)
            fan_rd_idx_next = fan_rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_cnt_reg    <= '0;
            fan_rd_idx_reg <= '0;
        end
        else
        begin
            fan_cnt_reg    <= fan_cnt_next;
            fan_rd_idx_reg <= fan_rd_idx_next;
        end
    end

    // Fanin buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.fan_push)
            fan_mem[fan_cnt_reg[IW-1:0]] <= tok_reg.name_index;
        if (cmd.fan_rd_start || cmd.fan_rd_step)
            fan_rd_reg <= fan_mem[fan_rd_addr];
    end

    // Clear sweep address
    assign clr_last = (clr_addr_reg == SW'(NAME_COUNT - 1));

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        if (cmd.clr_run)
            clr_addr_next = clr_last ? '0 : clr_addr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else
            clr_addr_reg <= clr_addr_next;
    end

    // Name table: shared write port for the sweep and flag updates
    always_comb
    begin
        mem_we    = cmd.clr_run | cmd.flag_write;
        mem_waddr = cmd.clr_run ? clr_addr_reg : slot;
        mem_wdata = cmd.clr_run ? flag_t'('0) : cmd.flag_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            flag_mem[mem_waddr] <= mem_wdata;
        if (cmd.flag_read)
            flag_rd_reg <= flag_mem[slot];
    end

    // Build the result item
    always_comb
    begin
        out_item.event_res = cmd.ev;
        case (cmd.sig_sel)
            SIG_TARGET: out_item.signal_index = target_reg;
            SIG_FANIN:  out_item.signal_index = fan_rd_reg;
            default:    out_item.signal_index = '0;
        endcase
        out_item.gate_kind = cmd.gate_en ? gate_reg : '0;
        out_item.last      = cmd.last;
    end

    // Output register: load on emit, drop on transfer
    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            out_item_reg <= out_item;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // Status back to the controller
    always_comb
    begin
        stat.tok_kind    = tok_reg.token_kind;
        stat.out_free    = out_free;
        stat.fan_full    = (fan_cnt_reg == CW'(MAX_FANIN));
        stat.fan_rd_last = ((CW'(fan_rd_idx_reg) + CW'(1)) == fan_cnt_reg);
        stat.slot_busy   = slot_busy;
        stat.flag        = flag_rd_reg;
        stat.clr_last    = clr_last;
    end

endmodule

// ===== src/bench_netlist_statement_parser.sv =====
// Bench netlist statement parser: one token per transfer, results through one output register.
// A token without a table lookup is loaded, handled in the exec state, and any result registered.
// A closing paren of a statement runs the slot unit and then a table read before the first
// result; further results (fanin events, both-io) follow one per cycle when the output is free.
// Reset and every EOF sweep the name table, with token_ready low throughout the sweep.
// Reset is asynchronous, active low; it clears the phase, error mark and output valid.
module bench_netlist_statement_parser #(
    parameter int NAME_COUNT = 4096,
    parameter int MAX_FANIN  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                token_valid,
    output logic                token_ready,
    input  bnsp_pkg::tok_item_t token,
    output logic                result_valid,
    input  logic                result_ready,
    output bnsp_pkg::res_item_t result
);
    import bnsp_pkg::*;

    bnsp_cmd_t  cmd;
    bnsp_stat_t stat;

    // Sequence statements and results
    bnsp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // Hold names, fanins, tables and the output register
    bnsp_dp #(
        .NAME_COUNT (NAME_COUNT),
        .MAX_FANIN  (MAX_FANIN)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .token        (token),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

// ===== src/bnsp_checker.sv =====
// Port-level checks for the bench netlist statement parser, bound to the top level.
// Uses bnsp_pkg and the macros of bench_netlist_statement_parser_assert.svh.
`include "bench_netlist_statement_parser_assert.svh"

module bnsp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                token_valid,
    input logic                token_ready,
    input bnsp_pkg::tok_item_t token,
    input logic                result_valid,
    input logic                result_ready,
    input bnsp_pkg::res_item_t result
);
    import bnsp_pkg::*;

    // A stalled result holds
    `BNSP_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

    // A token transfer always takes the next cycle to process
    `BNSP_ASSERT_NEXT(a_ready_drops, clk, rst_n, token_valid && token_ready, !token_ready, "token taken on back-to-back cycles")

    // Gate kind stays zero outside gate head and fanin events
    `BNSP_ASSERT_NOW(a_gate_zero, clk, rst_n, result_valid && result.event_res != EV_HEAD && result.event_res != EV_FANIN, result.gate_kind == GK_BUFF, "gate kind set on a non-gate event")

    // End of file events close the token's results
    `BNSP_ASSERT_NOW(a_end_last, clk, rst_n, result_valid && (result.event_res == EV_END_OK || result.event_res == EV_END_FAIL), result.last, "end event not marked last")

endmodule

bind bench_netlist_statement_parser bnsp_checker u_bnsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token        (token),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
